>>> hdl/assert_macros.svh
// Assertion macros shared by the codec RTL.
// Defining NO_ASSERTIONS compiles every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/tpxc_pkg.sv
// Package of the Type 7 password codec: transfer types, codes, key ROM and
// character helper functions. It depends on nothing else.
`default_nettype none

package tpxc_pkg;

    localparam int KEY_LEN     = 53;
    localparam int KEY_IDX_W   = 6;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = 3;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic REG_DIRECTION = 1'b0;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_BAD_LEN  = 2'd2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [1:0] {
        PH_SEED_TENS,
        PH_SEED_UNITS,
        PH_HEX_HIGH,
        PH_HEX_LOW
    } t_phase;

    typedef struct packed {
        logic [7:0] data_char;
        logic [3:0] seed_value;
        logic       first_of_string;
        logic       final_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       string_done;
        logic [1:0] error_code;
    } t_out_item;

    typedef struct packed {
        t_out_item [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]            count;
    } t_burst;

    function automatic logic [7:0] key_byte(input logic [KEY_IDX_W-1:0] idx);
        logic [7:0] k;
        case (idx)
            6'd0:  k = 8'h64;  6'd1:  k = 8'h73;  6'd2:  k = 8'h66;  6'd3:  k = 8'h64;
            6'd4:  k = 8'h3b;  6'd5:  k = 8'h6b;  6'd6:  k = 8'h66;  6'd7:  k = 8'h6f;
            6'd8:  k = 8'h41;  6'd9:  k = 8'h2c;  6'd10: k = 8'h2e;  6'd11: k = 8'h69;
            6'd12: k = 8'h79;  6'd13: k = 8'h65;  6'd14: k = 8'h77;  6'd15: k = 8'h72;
            6'd16: k = 8'h6b;  6'd17: k = 8'h6c;  6'd18: k = 8'h64;  6'd19: k = 8'h4a;
            6'd20: k = 8'h4b;  6'd21: k = 8'h44;  6'd22: k = 8'h48;  6'd23: k = 8'h53;
            6'd24: k = 8'h55;  6'd25: k = 8'h42;  6'd26: k = 8'h73;  6'd27: k = 8'h67;
            6'd28: k = 8'h76;  6'd29: k = 8'h63;  6'd30: k = 8'h61;  6'd31: k = 8'h36;
            6'd32: k = 8'h39;  6'd33: k = 8'h38;  6'd34: k = 8'h33;  6'd35: k = 8'h34;
            6'd36: k = 8'h6e;  6'd37: k = 8'h63;  6'd38: k = 8'h78;  6'd39: k = 8'h76;
            6'd40: k = 8'h39;  6'd41: k = 8'h38;  6'd42: k = 8'h37;  6'd43: k = 8'h33;
            6'd44: k = 8'h32;  6'd45: k = 8'h35;  6'd46: k = 8'h34;  6'd47: k = 8'h6b;
            6'd48: k = 8'h3b;  6'd49: k = 8'h66;  6'd50: k = 8'h67;  6'd51: k = 8'h38;
            6'd52: k = 8'h37;
            default: k = 8'h64;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_IDX_W-1:0] key_inc(input logic [KEY_IDX_W-1:0] idx);
        return (idx == KEY_IDX_W'(KEY_LEN - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (CHAR_ZERO + {4'b0000, nib}) : (8'h57 + {4'b0000, nib});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (is_digit(c)) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tpxc_engine.sv
// Codec state registers and the per-item logic that builds a burst of results.
// Depends on tpxc_pkg.
`default_nettype none

module tpxc_engine
    import tpxc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_take,
    input  wire t_in_item i_item,
    input  wire logic     i_direction,
    output t_burst        o_burst
);

    logic [KEY_IDX_W-1:0] r_key_idx, n_key_idx;
    t_phase               r_phase, n_phase;
    logic [3:0]           r_high, n_high;
    logic [3:0]           r_tens, n_tens;
    logic                 r_pair, n_pair;
    logic                 r_err, n_err;

    t_phase               eff_phase;
    logic                 eff_pair;
    logic                 eff_err;
    logic [KEY_IDX_W-1:0] enc_idx;
    logic [7:0]           enc_val;
    logic [4:0]           hv;
    logic                 dig_ok;
    logic [3:0]           digit;
    logic [6:0]           seed_sum;
    logic [6:0]           seed_mod;
    logic [7:0]           pair_val;
    logic                 bad;
    logic                 seed_hi;
    logic [3:0]           seed_lo;

    assign eff_phase = i_item.first_of_string ? PH_SEED_TENS : r_phase;
    assign eff_pair  = i_item.first_of_string ? 1'b0 : r_pair;
    assign eff_err   = i_item.first_of_string ? 1'b0 : r_err;

    assign enc_idx = i_item.first_of_string ? {2'b00, i_item.seed_value} : r_key_idx;
    assign enc_val = i_item.data_char ^ key_byte(enc_idx);

    assign hv       = hex_val(i_item.data_char);
    assign dig_ok   = is_digit(i_item.data_char);
    assign digit    = i_item.data_char[3:0];
    assign seed_sum = {r_tens, 3'b000} + {2'b00, r_tens, 1'b0} + {3'b000, digit};
    assign seed_mod = (seed_sum >= 7'(KEY_LEN)) ? seed_sum - 7'(KEY_LEN) : seed_sum;
    assign pair_val = {r_high, hv[3:0]} ^ key_byte(r_key_idx);

    assign seed_hi = (i_item.seed_value >= 4'd10);
    assign seed_lo = seed_hi ? i_item.seed_value - 4'd10 : i_item.seed_value;

    always_comb begin
        case (eff_phase) inside
            PH_SEED_TENS, PH_SEED_UNITS: bad = !dig_ok;
            default:                     bad = hv[4];
        endcase
    end

    always_comb begin
        n_key_idx = r_key_idx;
        n_phase   = r_phase;
        n_high    = r_high;
        n_tens    = r_tens;
        n_pair    = r_pair;
        n_err     = r_err;
        if (i_direction == DIR_ENCRYPT) begin
            n_key_idx = key_inc(enc_idx);
        end else begin
            n_phase = eff_phase;
            n_pair  = eff_pair;
            n_err   = eff_err;
            if (!eff_err) begin
                if (bad) begin
                    n_err = 1'b1;
                end else begin
                    unique case (eff_phase)
                        PH_SEED_TENS: begin
                            n_tens  = digit;
                            n_phase = PH_SEED_UNITS;
                        end
                        PH_SEED_UNITS: begin
                            n_key_idx = seed_mod[KEY_IDX_W-1:0];
                            n_phase   = PH_HEX_HIGH;
                        end
                        PH_HEX_HIGH: begin
                            n_high  = hv[3:0];
                            n_phase = PH_HEX_LOW;
                        end
                        PH_HEX_LOW: begin
                            n_key_idx = key_inc(r_key_idx);
                            n_phase   = PH_HEX_HIGH;
                            n_pair    = 1'b1;
                        end
                        default: n_phase = PH_SEED_TENS;
                    endcase
                end
            end
            if (i_item.final_of_string) begin
                n_phase = PH_SEED_TENS;
                n_pair  = 1'b0;
                n_err   = 1'b0;
            end
        end
    end

    always_comb begin
        o_burst = '0;
        if (i_direction == DIR_ENCRYPT) begin
            if (i_item.first_of_string) begin
                o_burst.res[0].out_char    = CHAR_ZERO + {7'b0000000, seed_hi};
                o_burst.res[1].out_char    = CHAR_ZERO + {4'b0000, seed_lo};
                o_burst.res[2].out_char    = hex_char(enc_val[7:4]);
                o_burst.res[3].out_char    = hex_char(enc_val[3:0]);
                o_burst.res[3].string_done = i_item.final_of_string;
                o_burst.count              = CNT_W'(4);
            end else begin
                o_burst.res[0].out_char    = hex_char(enc_val[7:4]);
                o_burst.res[1].out_char    = hex_char(enc_val[3:0]);
                o_burst.res[1].string_done = i_item.final_of_string;
                o_burst.count              = CNT_W'(2);
            end
        end else if (eff_err) begin
            if (i_item.final_of_string) begin
                o_burst.res[0].string_done = 1'b1;
                o_burst.res[0].error_code  = ERR_BAD_CHAR;
                o_burst.count              = CNT_W'(1);
            end
        end else if (bad) begin
            o_burst.res[0].string_done = i_item.final_of_string;
            o_burst.res[0].error_code  = ERR_BAD_CHAR;
            o_burst.count              = CNT_W'(1);
        end else if (eff_phase == PH_HEX_LOW) begin
            o_burst.res[0].out_char    = pair_val;
            o_burst.res[0].string_done = i_item.final_of_string;
            o_burst.count              = CNT_W'(1);
        end else if (i_item.final_of_string) begin
            o_burst.res[0].string_done = 1'b1;
            o_burst.res[0].error_code  = ERR_BAD_LEN;
            o_burst.count              = CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_idx <= '0;
            r_phase   <= PH_SEED_TENS;
            r_high    <= '0;
            r_tens    <= '0;
            r_pair    <= 1'b0;
            r_err     <= 1'b0;
        end else if (i_take) begin
            r_key_idx <= n_key_idx;
            r_phase   <= n_phase;
            r_high    <= n_high;
            r_tens    <= n_tens;
            r_pair    <= n_pair;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

>>> hdl/tpxc_burst.sv
// Result register that holds one burst and hands out one result per transfer.
// Depends on tpxc_pkg.
`default_nettype none

module tpxc_burst
    import tpxc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_burst i_burst,
    input  wire logic   i_out_stall,
    output logic        o_can_load,
    output logic        o_out_valid,
    output t_out_item   o_out_data
);

    t_out_item [MAX_RESULTS-1:0] r_res;
    logic [CNT_W-1:0]            r_left;
    logic [1:0]                  r_idx;
    logic                        out_xfer;

    assign o_out_valid = (r_left != '0);
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign o_can_load  = (r_left == '0) || ((r_left == CNT_W'(1)) && !i_out_stall);

    always_comb begin
        o_out_data         = r_res[r_idx];
        o_out_data.run_end = (r_left == CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_burst.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_burst.count;
            r_idx  <= '0;
        end else if (out_xfer) begin
            r_left <= r_left - 1'b1;
            r_idx  <= r_idx + 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> hdl/type7_password_xor_codec.sv
// Type 7 password codec top level: input register, APB direction register,
// codec engine and result serializer. Depends on tpxc_pkg, tpxc_engine,
// tpxc_burst and assert_macros.svh.
// An accepted item waits in the input register, driving the engine, until its
// burst loads into the serializer, which then presents its first result. The
// serializer gives one result per cycle while the output is not stalled; an
// encrypt item yields two results (four if first), a decrypt item at most one.
// Synchronous active-low reset clears direction, codec state, all valid flags.
`default_nettype none

`include "assert_macros.svh"

module type7_password_xor_codec
    import tpxc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic     r_direction;
    logic     r_in_valid;
    t_in_item r_in;
    logic     can_load;
    logic     take;
    logic     in_xfer;
    logic     reg_hit;
    t_burst   burst;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1] == REG_DIRECTION);
    assign prdata  = reg_hit ? {{(APB_DW-1){1'b0}}, r_direction} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCRYPT;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_direction <= pwdata[0];
        end
    end

    assign take       = r_in_valid && can_load;
    assign o_in_stall = r_in_valid && !take;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    tpxc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (r_in),
        .i_direction (r_direction),
        .o_burst     (burst)
    );

    tpxc_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_burst     (burst),
        .i_out_stall (i_out_stall),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `ASSERT_NEXT(a_encrypt_emits, i_clk, i_rst_n, take && (r_direction == DIR_ENCRYPT), o_out_valid)
    `ASSERT_IMPLY(a_encrypt_no_err, i_clk, i_rst_n, o_out_valid && (r_direction == DIR_ENCRYPT), o_out_data.error_code == ERR_NONE)
    `ASSERT_IMPLY(a_err_code_legal, i_clk, i_rst_n, o_out_valid, (o_out_data.error_code == ERR_NONE) || (o_out_data.error_code == ERR_BAD_CHAR) || (o_out_data.error_code == ERR_BAD_LEN))

endmodule

`default_nettype wire
